// ----- hdl/arp_pkg.sv -----
// shared constants, codes and command type for the arp neighbor cache
package arp_pkg;

  localparam int IP_W       = 32;
  localparam int MAC_W      = 48;
  localparam int SLOT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int ENTRIES_DEF = 8;

  // register reset values
  localparam logic [IP_W-1:0] LOCAL_IP_RST    = 32'hC0A8_00FA;
  localparam logic [IP_W-1:0] GATEWAY_IP_RST  = 32'hC0A8_0001;
  localparam logic [IP_W-1:0] SUBNET_MASK_RST = 32'hFFFF_FF00;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 2'd2;

  // operation codes
  localparam logic OP_LEARN   = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture a new transaction
    logic check;   // compare the entry read last cycle
    logic finish;  // write back and present the result
  } cmd_t;

endpackage

// ----- hdl/arp_ram.sv -----
// generic single write port ram with registered read
module arp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/arp_ctrl.sv -----
// controller: sequences the slot scan and the write-back
module arp_ctrl #(
  parameter int ENTRIES = arp_pkg::ENTRIES_DEF,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          hit,
  output logic          busy,
  output arp_pkg::cmd_t cmd,
  output logic [IW-1:0] rd_idx,
  output logic [IW-1:0] chk_idx
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  logic [1:0]    state, state_next;
  logic [IW-1:0] rd_idx_next, chk_idx_next;
  logic          chk_on, chk_on_next;

  always_comb begin
    state_next   = state;
    rd_idx_next  = rd_idx;
    chk_idx_next = chk_idx;
    chk_on_next  = chk_on;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          rd_idx_next = '0;
          chk_on_next = 1'b0;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.check    = chk_on;
        chk_idx_next = rd_idx;
        chk_on_next  = 1'b1;
        if (rd_idx != LAST) begin
          rd_idx_next = rd_idx + 1'b1;
        end
        if (chk_on && (hit || chk_idx == LAST)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      chk_on <= 1'b0;
    end else begin
      state  <= state_next;
      chk_on <= chk_on_next;
    end
    rd_idx  <= rd_idx_next;
    chk_idx <= chk_idx_next;
  end

  assign busy = (state != ST_IDLE);

endmodule

// ----- hdl/arp_dpath.sv -----
// datapath: config registers, entry stores, compare and result registers
module arp_dpath #(
  parameter int ENTRIES = arp_pkg::ENTRIES_DEF,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  arp_pkg::cmd_t                  cmd,
  input  logic [IW-1:0]                  rd_idx,
  input  logic [IW-1:0]                  chk_idx,
  output logic                           hit,
  input  logic                           op,
  input  logic [arp_pkg::IP_W-1:0]       ip_addr,
  input  logic [arp_pkg::MAC_W-1:0]      mac_addr,
  input  logic                           cfg_we,
  input  logic [arp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arp_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           done,
  output logic                           found,
  output logic [arp_pkg::MAC_W-1:0]      mac_out,
  output logic [arp_pkg::IP_W-1:0]       next_hop,
  output logic [arp_pkg::SLOT_W-1:0]     slot
);

  logic [arp_pkg::IP_W-1:0]  local_ip, gateway_ip, subnet_mask;
  logic                      op_q;
  logic [arp_pkg::IP_W-1:0]  target;
  logic [arp_pkg::MAC_W-1:0] mac_q, mac_hit;
  logic                      hit_q, free_found;
  logic [IW-1:0]             hit_idx, free_idx, wslot;
  logic [ENTRIES-1:0]        valid;
  logic [arp_pkg::IP_W-1:0]  ip_rdata;
  logic [arp_pkg::MAC_W-1:0] mac_rdata;
  logic                      learn_wr;
  logic [arp_pkg::IP_W-1:0]  hop_sel;
  logic [IW+arp_pkg::SLOT_W-1:0] slot_ext;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip    <= arp_pkg::LOCAL_IP_RST;
      gateway_ip  <= arp_pkg::GATEWAY_IP_RST;
      subnet_mask <= arp_pkg::SUBNET_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arp_pkg::REG_LOCAL_IP:    local_ip    <= cfg_data;
        arp_pkg::REG_GATEWAY_IP:  gateway_ip  <= cfg_data;
        arp_pkg::REG_SUBNET_MASK: subnet_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // next hop: destination on learn or when on-link, else gateway
  always_comb begin
    if (op == arp_pkg::OP_LEARN) begin
      hop_sel = ip_addr;
    end else if ((ip_addr & subnet_mask) == (local_ip & subnet_mask)) begin
      hop_sel = ip_addr;
    end else begin
      hop_sel = gateway_ip;
    end
  end

  assign hit      = cmd.check && valid[chk_idx] && (ip_rdata == target);
  assign wslot    = hit_q ? hit_idx : (free_found ? free_idx : '0);
  assign learn_wr = cmd.finish && (op_q == arp_pkg::OP_LEARN);
  assign slot_ext = {{arp_pkg::SLOT_W{1'b0}}, wslot};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= op;
      target     <= hop_sel;
      mac_q      <= mac_addr;
      hit_q      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.check) begin
      if (hit) begin
        hit_q   <= 1'b1;
        hit_idx <= chk_idx;
        mac_hit <= mac_rdata;
      end
      if (!valid[chk_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (learn_wr) begin
      valid[wslot] <= 1'b1;
    end
  end

  arp_ram #(.WIDTH(arp_pkg::IP_W), .DEPTH(ENTRIES)) u_ip_ram (
    .clk   (clk),
    .we    (learn_wr && !hit_q),
    .waddr (wslot),
    .wdata (target),
    .raddr (rd_idx),
    .rdata (ip_rdata)
  );

  arp_ram #(.WIDTH(arp_pkg::MAC_W), .DEPTH(ENTRIES)) u_mac_ram (
    .clk   (clk),
    .we    (learn_wr),
    .waddr (wslot),
    .wdata (mac_q),
    .raddr (rd_idx),
    .rdata (mac_rdata)
  );

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      found    <= hit_q;
      next_hop <= target;
      if (op_q == arp_pkg::OP_LEARN) begin
        mac_out <= '0;
        slot    <= slot_ext[arp_pkg::SLOT_W-1:0];
      end else if (hit_q) begin
        mac_out <= mac_hit;
        slot    <= slot_ext[arp_pkg::SLOT_W-1:0];
      end else begin
        mac_out <= '0;
        slot    <= '0;
      end
    end
  end

endmodule

// ----- hdl/arp_neighbor_cache_core.sv -----
// top level of the arp neighbor cache: controller plus datapath
//
//   channel   handshake             payload
//   --------  --------------------  -----------------------------------------
//   request   start / busy          op, ip_addr, mac_addr
//   result    done (one cycle)      found, mac_out, next_hop, slot
//   config    cfg_we                cfg_index, cfg_data
//
// a request transaction is taken when start is high and busy is low
// the slots are scanned one per cycle through the registered read of the
// entry rams; the scan stops at the first hit or after the last slot (miss),
// after which busy falls and the next transaction can be taken
// the result shows for exactly one cycle with done; the receiver cannot stall
// rst (synchronous, active high) clears all valid bits and loads the register
// reset values; entry contents need no clearing
module arp_neighbor_cache_core #(
  parameter int ENTRIES = arp_pkg::ENTRIES_DEF,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  // request
  input  logic                           start,
  output logic                           busy,
  input  logic                           op,
  input  logic [arp_pkg::IP_W-1:0]       ip_addr,
  input  logic [arp_pkg::MAC_W-1:0]      mac_addr,
  // configuration
  input  logic                           cfg_we,
  input  logic [arp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arp_pkg::CFG_DATA_W-1:0] cfg_data,
  // result
  output logic                           done,
  output logic                           found,
  output logic [arp_pkg::MAC_W-1:0]      mac_out,
  output logic [arp_pkg::IP_W-1:0]       next_hop,
  output logic [arp_pkg::SLOT_W-1:0]     slot
);

  arp_pkg::cmd_t cmd;
  logic [IW-1:0] rd_idx;   // slot being read
  logic [IW-1:0] chk_idx;  // slot whose data is being compared
  logic          hit;

  // sequencing: idle, scan slots, write back and present result
  arp_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .hit     (hit),
    .busy    (busy),
    .cmd     (cmd),
    .rd_idx  (rd_idx),
    .chk_idx (chk_idx)
  );

  // registers, entry stores and next-hop selection
  arp_dpath #(.ENTRIES(ENTRIES)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .chk_idx   (chk_idx),
    .hit       (hit),
    .op        (op),
    .ip_addr   (ip_addr),
    .mac_addr  (mac_addr),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .found     (found),
    .mac_out   (mac_out),
    .next_hop  (next_hop),
    .slot      (slot)
  );

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for arp_neighbor_cache_core: directed table, then randomized phases
module tb_top;
  import arp_pkg::*;

  localparam int SLOTS           = ENTRIES_DEF;
  localparam int RUN_LIMIT       = 400000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int DIR_ROWS        = 23;
  // index 3 is not mapped, so a write there must leave every register alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // one answer of the cache, in port order
  typedef struct packed {
    logic               found;
    logic [MAC_W-1:0]   mac;
    logic [IP_W-1:0]    hop;
    logic [SLOT_W-1:0]  slot;
  } answer_t;

  // one directed request; when typed is set the answer is written out by hand
  typedef struct packed {
    logic              op;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic              typed;
    answer_t           want;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   op;
  logic [IP_W-1:0]        ip_addr;
  logic [MAC_W-1:0]       mac_addr;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   done;
  logic                   found;
  logic [MAC_W-1:0]       mac_out;
  logic [IP_W-1:0]        next_hop;
  logic [SLOT_W-1:0]      slot;

  // mirror of the register file and the neighbor table
  logic [IP_W-1:0]   local_q;
  logic [IP_W-1:0]   gateway_q;
  logic [IP_W-1:0]   mask_q;
  logic [IP_W-1:0]   table_ip    [SLOTS];
  logic [MAC_W-1:0]  table_mac   [SLOTS];
  logic              table_valid [SLOTS];

  answer_t   answers_due [$];
  answer_t   oldest_due;
  dir_row_t  dir_rows [DIR_ROWS];
  int        mismatches = 0;
  int        cycles = 0;

  arp_neighbor_cache_core #(.ENTRIES(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .ip_addr   (ip_addr),
    .mac_addr  (mac_addr),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .found     (found),
    .mac_out   (mac_out),
    .next_hop  (next_hop),
    .slot      (slot)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // hard stop in case the block hangs or stops answering
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // answer of the cache for one transaction; updates the table mirror on learn
  function automatic answer_t neighbor_answer(logic op_i, logic [IP_W-1:0] ip_i,
                                              logic [MAC_W-1:0] mac_i);
    answer_t          a;
    logic [IP_W-1:0]  target;
    int               hit;
    a = '0;
    // resolve goes direct on the local subnet, through the gateway elsewhere
    if (op_i == OP_LEARN || (ip_i & mask_q) == (local_q & mask_q))
      target = ip_i;
    else
      target = gateway_q;
    a.hop = target;
    // lowest valid slot holding the target wins
    hit = -1;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (table_valid[i] && table_ip[i] == target) hit = i;
    if (op_i == OP_LEARN) begin
      if (hit >= 0) begin
        a.found = 1'b1;
      end else begin
        // lowest free slot, or slot 0 once the table is full
        hit = 0;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!table_valid[i]) hit = i;
        table_ip[hit]    = ip_i;
        table_valid[hit] = 1'b1;
      end
      table_mac[hit] = mac_i;
      a.slot = SLOT_W'(hit);
    end else if (hit >= 0) begin
      a.found = 1'b1;
      a.mac   = table_mac[hit];
      a.slot  = SLOT_W'(hit);
    end
    return a;
  endfunction

  // hands one request transaction to the block, after an idle gap when gap is nonzero
  task automatic send_request(logic op_i, logic [IP_W-1:0] ip_i, logic [MAC_W-1:0] mac_i,
                              int unsigned gap, logic typed, answer_t want);
    answer_t predicted;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start    <= 1'b1;
    op       <= op_i;
    ip_addr  <= ip_i;
    mac_addr <= mac_i;
    // taken at the first rising edge that sees busy low
    do @(posedge clk); while (busy);
    predicted = neighbor_answer(op_i, ip_i, mac_i);
    answers_due.push_back(typed ? want : predicted);
  endtask

  // one register write; the mirror follows at the edge that takes it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_LOCAL_IP:    local_q   = val;
      REG_GATEWAY_IP:  gateway_q = val;
      REG_SUBNET_MASK: mask_q    = val;
      default: ;
    endcase
  endtask

  // stop requesting and wait until the block has answered everything and gone idle
  task automatic settle_cache();
    @(negedge clk);
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  // every done pulse is one result transaction, checked against the oldest answer due
  always @(posedge clk) begin
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got found %0d mac %h hop %h slot %0d",
                 $time, found, mac_out, next_hop, slot);
        mismatches++;
      end else begin
        oldest_due = answers_due.pop_front();
        if (found !== oldest_due.found) begin
          $display("%0t: found expected %0d got %0d", $time, oldest_due.found, found);
          mismatches++;
        end
        if (mac_out !== oldest_due.mac) begin
          $display("%0t: mac_out expected %h got %h", $time, oldest_due.mac, mac_out);
          mismatches++;
        end
        if (next_hop !== oldest_due.hop) begin
          $display("%0t: next_hop expected %h got %h", $time, oldest_due.hop, next_hop);
          mismatches++;
        end
        if (slot !== oldest_due.slot) begin
          $display("%0t: slot expected %0d got %0d", $time, oldest_due.slot, slot);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic              op_v;
    logic [IP_W-1:0]   ip_v;
    logic [MAC_W-1:0]  mac_v;
    logic [IP_W-1:0]   lcl;
    logic [IP_W-1:0]   gw;
    logic [IP_W-1:0]   msk;
    logic [63:0]       wide;
    int unsigned       gap;
    int unsigned       quiet_run;
    int unsigned       pick;

    rst        = 1'b1;
    start      = 1'b0;
    op         = OP_LEARN;
    ip_addr    = '0;
    mac_addr   = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_LOCAL_IP;
    cfg_data   = '0;
    quiet_run  = 0;
    local_q    = LOCAL_IP_RST;
    gateway_q  = GATEWAY_IP_RST;
    mask_q     = SUBNET_MASK_RST;
    for (int i = 0; i < SLOTS; i++) begin
      table_ip[i]    = '0;
      table_mac[i]   = '0;
      table_valid[i] = 1'b0;
    end

    // directed part under the reset registers (local .250, gateway .1, /24)
    dir_rows = '{
      // empty table: on-subnet and off-subnet misses
      '{OP_RESOLVE, 32'hC0A8_0005, 48'h0, 1'b1, '{1'b0, 48'h0, 32'hC0A8_0005, 3'd0}},
      '{OP_RESOLVE, 32'h0A00_0001, 48'hFFFF_FFFF_FFFF, 1'b1,
        '{1'b0, 48'h0, 32'hC0A8_0001, 3'd0}},
      // learn the gateway, resolve through it, then refresh its mac
      '{OP_LEARN,   32'hC0A8_0001, 48'h0, 1'b1, '{1'b0, 48'h0, 32'hC0A8_0001, 3'd0}},
      '{OP_RESOLVE, 32'h0808_0808, 48'h0, 1'b1, '{1'b1, 48'h0, 32'hC0A8_0001, 3'd0}},
      '{OP_LEARN,   32'hC0A8_0001, 48'hFFFF_FFFF_FFFF, 1'b1,
        '{1'b1, 48'h0, 32'hC0A8_0001, 3'd0}},
      '{OP_RESOLVE, 32'hFFFF_FFFF, 48'h0, 1'b1,
        '{1'b1, 48'hFFFF_FFFF_FFFF, 32'hC0A8_0001, 3'd0}},
      // extreme addresses fill the next free slots
      '{OP_LEARN,   32'h0000_0000, 48'hAAAA_AAAA_AAAA, 1'b1, '{1'b0, 48'h0, 32'h0, 3'd1}},
      '{OP_LEARN,   32'hFFFF_FFFF, 48'h5555_5555_5555, 1'b1,
        '{1'b0, 48'h0, 32'hFFFF_FFFF, 3'd2}},
      '{OP_LEARN,   32'hC0A8_00FA, 48'h1234_5678_9ABC, 1'b1,
        '{1'b0, 48'h0, 32'hC0A8_00FA, 3'd3}},
      '{OP_RESOLVE, 32'hC0A8_00FA, 48'h0, 1'b1,
        '{1'b1, 48'h1234_5678_9ABC, 32'hC0A8_00FA, 3'd3}},
      '{OP_LEARN,   32'hC0A8_0010, 48'h0, 1'b1, '{1'b0, 48'h0, 32'hC0A8_0010, 3'd4}},
      '{OP_LEARN,   32'hC0A8_0011, 48'h0, 1'b1, '{1'b0, 48'h0, 32'hC0A8_0011, 3'd5}},
      '{OP_LEARN,   32'hC0A8_0012, 48'h0, 1'b1, '{1'b0, 48'h0, 32'hC0A8_0012, 3'd6}},
      '{OP_LEARN,   32'hC0A8_0013, 48'h0, 1'b1, '{1'b0, 48'h0, 32'hC0A8_0013, 3'd7}},
      // full table: slot 0 is replaced, which evicts the gateway
      '{OP_LEARN,   32'hC0A8_0020, 48'h0A0B_0C0D_0E0F, 1'b1,
        '{1'b0, 48'h0, 32'hC0A8_0020, 3'd0}},
      '{OP_RESOLVE, 32'h0102_0304, 48'h0, 1'b1, '{1'b0, 48'h0, 32'hC0A8_0001, 3'd0}},
      '{OP_RESOLVE, 32'hC0A8_0020, 48'h0, 1'b1,
        '{1'b1, 48'h0A0B_0C0D_0E0F, 32'hC0A8_0020, 3'd0}},
      '{OP_RESOLVE, 32'hC0A8_0012, 48'h0, 1'b0, '0},
      '{OP_LEARN,   32'hC0A8_0012, 48'hFEDC_BA98_7654, 1'b0, '0},
      '{OP_RESOLVE, 32'hC0A8_0012, 48'h0, 1'b0, '0},
      '{OP_RESOLVE, 32'h0000_0000, 48'h0000_0000_0001, 1'b0, '0},
      '{OP_LEARN,   32'hC0A8_0001, 48'h6655_4433_2211, 1'b0, '0},
      '{OP_RESOLVE, 32'hC0A8_0099, 48'h0, 1'b0, '0}
    };

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIR_ROWS; k++)
      send_request(dir_rows[k].op, dir_rows[k].ip, dir_rows[k].mac, $urandom_range(0, 10),
                   dir_rows[k].typed, dir_rows[k].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      // registers change only while the cache is idle
      settle_cache();
      lcl = (ph == 2) ? 32'h0 : (ph == 3) ? 32'hFFFF_FFFF : $urandom;
      if (ph == 0)
        msk = 32'h0;                                   // every address is local
      else if (ph == 1)
        msk = 32'hFFFF_FFFF;                           // only the own address is local
      else if (ph == 5)
        msk = $urandom;                                // non-contiguous mask
      else
        msk = ~(32'hFFFF_FFFF >> $urandom_range(8, 30));
      if (ph == 2)
        gw = 32'hFFFF_FFFF;
      else if (ph == 3)
        gw = 32'h0;
      else if (ph == 4)
        gw = $urandom;
      else
        gw = (lcl & msk) | (~msk & IP_W'($urandom_range(1, 11)));
      write_reg(REG_LOCAL_IP, lcl);
      write_reg(REG_SPARE, $urandom);
      write_reg(REG_GATEWAY_IP, gw);
      write_reg(REG_SUBNET_MASK, msk);
      @(negedge clk);
      cfg_we <= 1'b0;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        op_v = ($urandom_range(0, 19) < 9) ? OP_LEARN : OP_RESOLVE;
        // mostly a small pool of neighbors so that learns refresh and resolves hit
        pick = $urandom_range(0, 9);
        if (pick < 5)
          ip_v = (local_q & mask_q) | (~mask_q & IP_W'($urandom_range(0, 11)));
        else if (pick < 7)
          ip_v = gateway_q;
        else if (pick == 7)
          ip_v = local_q;
        else if (pick == 8)
          ip_v = $urandom;
        else
          ip_v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        wide = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        mac_v = (pick == 0) ? '0 : (pick == 1) ? '1 : wide[MAC_W-1:0];
        // random gaps, broken up now and then by back-to-back runs
        if (quiet_run > 0) begin
          gap = 0;
          quiet_run--;
        end else begin
          gap = $urandom_range(0, 10);
          if ($urandom_range(0, 24) == 0) quiet_run = 15;
        end
        send_request(op_v, ip_v, mac_v, gap, 1'b0, '0);
      end
    end

    settle_cache();
    if (mismatches == 0 && answers_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/arp_pkg.sv
hdl/arp_ram.sv
hdl/arp_ctrl.sv
hdl/arp_dpath.sv
hdl/arp_neighbor_cache_core.sv
tb/tb_top.sv
